[rtl/spmr_pkg.sv]
package spmr_pkg;

    // generator constants
    localparam logic [30:0] LCG_MOD  = 31'h7FFF_FFFF;
    localparam logic [14:0] LCG_MULT = 15'd16807;
    localparam int          PROD_W   = 46;

    // shuffle table geometry
    localparam int TABLE_DEPTH = 32;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);

    // table depth plus eight discarded steps
    localparam int          WARMUP_STEPS = TABLE_DEPTH + 8;
    localparam int          COUNT_W      = $clog2(WARMUP_STEPS + 1);

    // fraction output
    localparam int          FRAC_W   = 24;
    localparam logic [23:0] FRAC_MAX = 24'd16777214;

    typedef logic [30:0] lcg_word_t;

    // table port control between the sequencer and the table memory
    typedef struct packed {
        logic              we;
        logic [SLOT_W-1:0] waddr;
        lcg_word_t         wdata;
        logic              re;
        logic [SLOT_W-1:0] raddr;
    } tbl_ctrl_t;

endpackage

[rtl/spmr_ram.sv]
module spmr_ram #(
    parameter int WIDTH = 31,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/shuffled_park_miller_rng.sv]
// channel | direction | handshake           | payload
// input   | in        | in_valid / in_stall   | command, seed_value
// output  | out       | out_valid / out_stall | raw_value, fraction
//
// a draw steps through accept, multiply and fold; the result is registered
// in the fold state once the output is free; one generator step is a
// multiply state and a fold state through the single shared multiply-mod unit
// a reseed (or the first draw after reset) adds 40 generator steps
// reset clears the generator to one and marks the table as not initialized;
// table contents are left alone, warm-up writes every entry before any read
// in_stall is high whenever a transaction is in progress; a stalled result
// holds the sequencer in its last cycle, so nothing moves until it is taken
module shuffled_park_miller_rng (
    input  logic        clk,
    input  logic        rst_n,
    // input channel
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [0:0]  command,
    input  logic [30:0] seed_value,
    // output channel
    output logic        out_valid,
    input  logic        out_stall,
    output logic [30:0] raw_value,
    output logic [23:0] fraction
);

    // sequencer states
    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_FOLD = 2'd2;

    logic [1:0]                         state_reg, state_next;
    logic                               init_reg, init_next;
    logic [spmr_pkg::COUNT_W-1:0]       count_reg, count_next;
    spmr_pkg::lcg_word_t                x_reg, x_next;
    spmr_pkg::lcg_word_t                last_pick_reg, last_pick_next;
    logic [spmr_pkg::PROD_W-1:0]        prod_reg, prod_next;
    logic                               out_valid_reg, out_valid_next;
    spmr_pkg::lcg_word_t                raw_reg, raw_next;
    logic [spmr_pkg::FRAC_W-1:0]        frac_reg, frac_next;

    spmr_pkg::tbl_ctrl_t                tbl;
    spmr_pkg::lcg_word_t                tbl_rdata;

    logic                               accept;
    logic                               out_free;
    logic [31:0]                        fold_sum;
    spmr_pkg::lcg_word_t                step_value;
    spmr_pkg::lcg_word_t                seed_fixed;
    logic [spmr_pkg::FRAC_W-1:0]        frac_shift;

    assign accept   = in_valid && !in_stall;
    assign out_free = !out_valid_reg || !out_stall;

    // mod 2^31-1 fold of the registered product: low 31 bits plus the high part
    assign fold_sum   = {1'b0, prod_reg[30:0]}
                      + {17'd0, prod_reg[spmr_pkg::PROD_W-1:31]};
    assign step_value = (fold_sum >= {1'b0, spmr_pkg::LCG_MOD})
                      ? 31'(fold_sum - {1'b0, spmr_pkg::LCG_MOD})
                      : fold_sum[30:0];

    // zero and all-ones seeds would lock the generator
    assign seed_fixed = (seed_value == '0 || seed_value == spmr_pkg::LCG_MOD)
                      ? 31'd1 : seed_value;

    assign frac_shift = tbl_rdata[30:7];

    always_comb
    begin
        state_next     = state_reg;
        init_next      = init_reg;
        count_next     = count_reg;
        x_next         = x_reg;
        last_pick_next = last_pick_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg;
        raw_next       = raw_reg;
        frac_next      = frac_reg;

        tbl.we    = 1'b0;
        tbl.waddr = count_reg[spmr_pkg::SLOT_W-1:0] - 1'b1;
        tbl.wdata = step_value;
        tbl.re    = 1'b0;
        // slot = last_pick / 2^26, already within the table
        tbl.raddr = last_pick_reg[30:31-spmr_pkg::SLOT_W];

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_MUL;
                    count_next = spmr_pkg::COUNT_W'(spmr_pkg::WARMUP_STEPS);
                    if (command[0])
                    begin
                        x_next    = seed_fixed;
                        init_next = 1'b1;
                    end
                    else
                    begin
                        // first draw after reset warms up from the stored value
                        init_next = (last_pick_reg == '0);
                    end
                end
            end
            S_MUL:
            begin
                prod_next  = spmr_pkg::PROD_W'(x_reg)
                           * spmr_pkg::PROD_W'(spmr_pkg::LCG_MULT);
                tbl.re     = !init_reg;
                state_next = S_FOLD;
            end
            S_FOLD:
            begin
                if (init_reg)
                begin
                    x_next     = step_value;
                    count_next = count_reg - 1'b1;
                    // last table-depth steps fill the table top slot first
                    tbl.we     = (count_reg <= spmr_pkg::COUNT_W'(spmr_pkg::TABLE_DEPTH));
                    state_next = S_MUL;
                    if (count_reg == spmr_pkg::COUNT_W'(1))
                    begin
                        init_next      = 1'b0;
                        last_pick_next = step_value;
                    end
                end
                else if (out_free)
                begin
                    x_next         = step_value;
                    tbl.we         = 1'b1;
                    tbl.waddr      = tbl.raddr;
                    last_pick_next = tbl_rdata;
                    raw_next       = tbl_rdata;
                    frac_next      = (frac_shift > spmr_pkg::FRAC_MAX)
                                   ? spmr_pkg::FRAC_MAX : frac_shift;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            init_reg      <= 1'b0;
            count_reg     <= '0;
            x_reg         <= 31'd1;
            last_pick_reg <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            init_reg      <= init_next;
            count_reg     <= count_next;
            x_reg         <= x_next;
            last_pick_reg <= last_pick_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        raw_reg  <= raw_next;
        frac_reg <= frac_next;
    end

    spmr_ram #(
        .WIDTH (31),
        .DEPTH (spmr_pkg::TABLE_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl.we),
        .waddr (tbl.waddr),
        .wdata (tbl.wdata),
        .re    (tbl.re),
        .raddr (tbl.raddr),
        .rdata (tbl_rdata)
    );

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;
    assign raw_value = raw_reg;
    assign fraction  = frac_reg;

    // generator never sits at zero or at the modulus
    a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        x_reg != '0 && x_reg != spmr_pkg::LCG_MOD)
        else $error("generator state out of range");

    // a result appears only at the end of a draw fold cycle
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == S_FOLD && !init_reg))
        else $error("result without a draw");

    // draws only run once the table has been initialized
    a_draw_ready: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE && !init_reg) |-> last_pick_reg != '0)
        else $error("draw from an uninitialized table");

    // table is written only in fold cycles
    a_write_fold: assert property (@(posedge clk) disable iff (!rst_n)
        tbl.we |-> state_reg == S_FOLD)
        else $error("table write outside fold cycle");

endmodule
